FILE: rtl/core/ard_pkg.sv
// Shared types and constants for the aligned range decomposer.
`timescale 1ns / 1ps

package ard_pkg;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned LEVEL_W     = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [FIELD_W-1:0] range_low;
    logic [FIELD_W-1:0] range_high;
  } range_t;

  typedef struct packed {
    logic [FIELD_W-1:0] block_start;
    logic [LEVEL_W-1:0] block_level;
    logic               last;
    logic               error;
  } block_t;

endpackage

FILE: rtl/core/ard_range_if.sv
// Valid/ready channel that carries one input range item.
`timescale 1ns / 1ps

interface ard_range_if import ard_pkg::*; ();
  logic   valid;
  logic   ready;
  range_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/ard_block_if.sv
// Valid/ready channel that carries one aligned block item.
`timescale 1ns / 1ps

interface ard_block_if import ard_pkg::*; ();
  logic   valid;
  logic   ready;
  block_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/ard_front.sv
// Front end: accept range items, check them and turn them into work entries.
`timescale 1ns / 1ps

module ard_front import ard_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 32,
  parameter int unsigned ENTRY_W    = 2 * ADDR_WIDTH + 3
) (
  ard_range_if.sink           in_ch,
  input  logic                one_based,
  input  logic                q_full,
  output logic                q_push,
  output logic [ENTRY_W-1:0]  q_push_data
);

  localparam int unsigned AW    = ADDR_WIDTH;
  localparam int unsigned REM_W = AW + 1;

  typedef struct packed {
    logic             err;
    logic             bias;
    logic [AW-1:0]    pos;
    logic [REM_W-1:0] rem;
  } entry_t;

  logic [AW-1:0] low;
  logic [AW-1:0] high;
  entry_t        entry;

  assign low  = in_ch.payload.range_low[AW-1:0];
  assign high = in_ch.payload.range_high[AW-1:0];

  always_comb begin
    // Empty range, or a one-based range that would start below zero.
    entry.err  = (low > high) || (one_based && (low == '0));
    entry.bias = one_based;
    entry.pos  = low - {{(AW-1){1'b0}}, one_based};
    entry.rem  = {1'b0, high} - {1'b0, low} + REM_W'(1);
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_push_data = ENTRY_W'(entry);

endmodule

FILE: rtl/core/ard_queue.sv
// Short FIFO that decouples the front end from the block generator.
`timescale 1ns / 1ps

module ard_queue import ard_pkg::*; #(
  parameter int unsigned WIDTH = 67
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/ard_back.sv
// Back end: walk one range and emit its aligned blocks into an output register.
`timescale 1ns / 1ps

module ard_back import ard_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 32,
  parameter int unsigned ENTRY_W    = 2 * ADDR_WIDTH + 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_pop_data,
  output logic               q_pop,
  ard_block_if.source        out_ch
);

  localparam int unsigned AW    = ADDR_WIDTH;
  localparam int unsigned REM_W = AW + 1;

  typedef struct packed {
    logic             err;
    logic             bias;
    logic [AW-1:0]    pos;
    logic [REM_W-1:0] rem;
  } entry_t;

  entry_t           head;
  logic             busy_r, busy_nxt;
  logic             err_r;
  logic             bias_r;
  logic [AW-1:0]    pos_r;
  logic [REM_W-1:0] rem_r;
  logic             out_valid_r, out_valid_nxt;
  block_t           out_data_r;

  logic [LEVEL_W-1:0] tz;
  logic [LEVEL_W-1:0] msb;
  logic [LEVEL_W-1:0] level;
  logic [REM_W-1:0]   size;
  logic [AW-1:0]      start;
  logic               finish;
  logic               advance;
  logic               emit;
  block_t             result;

  assign head = entry_t'(q_pop_data);

  always_comb begin
    // Alignment of the current position; position zero is aligned to everything.
    tz = LEVEL_W'(AW);
    for (int i = AW - 1; i >= 0; i--) begin
      if (pos_r[i]) tz = LEVEL_W'(i);
    end
    // Largest power of two that still fits in what is left.
    msb = '0;
    for (int i = 0; i < REM_W; i++) begin
      if (rem_r[i]) msb = LEVEL_W'(i);
    end
    level  = (tz < msb) ? tz : msb;
    size   = REM_W'(1) << level;
    start  = pos_r + {{(AW-1){1'b0}}, bias_r};
    finish = err_r || (rem_r == size);

    if (err_r) begin
      result.block_start = '0;
      result.block_level = '0;
      result.last        = 1'b1;
      result.error       = 1'b1;
    end else begin
      result.block_start = FIELD_W'(start);
      result.block_level = level;
      result.last        = finish;
      result.error       = 1'b0;
    end
  end

  assign advance = !out_valid_r || out_ch.ready;
  assign emit    = busy_r && advance;
  assign q_pop   = !q_empty && (!busy_r || (emit && finish));

  always_comb begin
    busy_nxt = busy_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
    end else if (emit && finish) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      err_r  <= head.err;
      bias_r <= head.bias;
      pos_r  <= head.pos;
      rem_r  <= head.rem;
    end else if (emit) begin
      pos_r <= pos_r + size[AW-1:0];
      rem_r <= rem_r - size;
    end
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

endmodule

FILE: rtl/core/aligned_range_decomposer_core.sv
// Top level of the aligned power-of-two range decomposer.
// Path: each accepted item passes through the queue and the walker registers, and its blocks leave the output register.
// Throughput: one block per cycle while the output accepts; an item yields 1 to
// 2*ADDR_WIDTH-2 blocks (62 at 32 bits), an error item yields one.
// Reset: synchronous active-low rst_n clears the queue, walker and output valid, and
// sets one_based to 0. No memory clearing pass is needed.
`timescale 1ns / 1ps

module aligned_range_decomposer_core import ard_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ard_range_if.sink   in_ch,
  ard_block_if.source out_ch,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  // Queue entry: error flag, bias, lowered start position, remaining length.
  localparam int unsigned ENTRY_W = 2 * ADDR_WIDTH + 3;

  logic               one_based_r;
  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_pop_data;
  logic               q_empty;

  // Hold the mode bit; the user must write it only while the block is idle, the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_based_r <= 1'b0;
    end else if (cfg_wr_en) begin
      one_based_r <= cfg_wr_data;
    end
  end

  // Classify each item: drop bad ranges to a single error entry, lower one-based bounds.
  ard_front #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .in_ch       (in_ch),
    .one_based   (one_based_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Buffer classified items so the front keeps accepting while blocks stream out.
  ard_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Advance one aligned block per cycle while the output accepts, largest aligned block that still fits.
  ard_back #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop_data (q_pop_data),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: sim/ard_checker.sv
// Channel monitor that predicts the aligned block items and compares them with the output.
`timescale 1ns / 1ps

module ard_checker import ard_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  ard_range_if  in_ch,
  ard_block_if  out_ch,
  input  logic  cfg_wr_en,
  input  logic  cfg_wr_data,
  output int    mismatch_count,
  output int    blocks_owed
);

  localparam int unsigned MAX_BLOCKS = 2 * ADDR_WIDTH - 2;

  block_t blocks_due[$];
  logic   one_based_q;

  // Cover one range with its aligned blocks, lowest first.
  task automatic split_range(input range_t r);
    logic [63:0] amask;
    logic [63:0] pos;
    logic [63:0] last_pos;
    logic [63:0] step;
    logic        bias;
    int unsigned level;
    int unsigned count;
    block_t      b;
    amask    = (64'd1 << ADDR_WIDTH) - 64'd1;
    pos      = {32'd0, r.range_low} & amask;
    last_pos = {32'd0, r.range_high} & amask;
    bias     = one_based_q;
    count    = 0;
    if (pos > last_pos || (bias && pos == 64'd0)) begin
      b = '{block_start: '0, block_level: '0, last: 1'b1, error: 1'b1};
      blocks_due = {blocks_due, b};
      return;
    end
    if (bias) begin
      pos      = pos - 64'd1;
      last_pos = last_pos - 64'd1;
    end
    while (pos <= last_pos && count < MAX_BLOCKS) begin
      level = 0;
      while (level < ADDR_WIDTH) begin
        step = 64'd1 << (level + 1);
        if ((pos & (step - 64'd1)) != 64'd0 || pos + step - 64'd1 > last_pos) break;
        level++;
      end
      b.block_start = 32'(pos + {63'd0, bias});
      b.block_level = 6'(level);
      b.error       = 1'b0;
      pos           = pos + (64'd1 << level);
      b.last        = (pos > last_pos);
      blocks_due    = {blocks_due, b};
      count++;
    end
  endtask

  always @(posedge clk) begin
    block_t want;
    block_t got;
    if (!rst_n) begin
      one_based_q    = 1'b0;
      mismatch_count = 0;
      blocks_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (blocks_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected block expected none, actual start=%h level=%0d last=%b error=%b",
                   $time, got.block_start, got.block_level, got.last, got.error);
        end else begin
          want = blocks_due.pop_front();
          if (got.block_start !== want.block_start || got.block_level !== want.block_level ||
              got.last !== want.last || got.error !== want.error) begin
            mismatch_count++;
            $display("%0t: block mismatch expected start=%h level=%0d last=%b error=%b, %s",
                     $time, want.block_start, want.block_level, want.last, want.error,
                     $sformatf("actual start=%h level=%0d last=%b error=%b",
                               got.block_start, got.block_level, got.last, got.error));
          end
        end
      end
      if (cfg_wr_en) one_based_q = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) split_range(in_ch.payload);
    end
    blocks_owed = blocks_due.size();
  end

endmodule

FILE: sim/tb_top.sv
// Stimulus and verdict for the aligned range decomposer.
`timescale 1ns / 1ps

module tb_top;
  import ard_pkg::*;

  localparam int unsigned ADDR_WIDTH    = 32;
  localparam int          RANDOM_PHASES = 4;
  localparam int          PHASE_ITEMS   = 20;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_LIMIT   = 200000;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  int   mismatch_count;
  int   blocks_owed;

  // Sender burst state: items left in the current burst.
  int          burst_left;
  // Receiver stall state: a rotating ready pattern and its remaining lifetime.
  logic [31:0] stall_pattern;
  int          stall_age;

  ard_range_if in_ch ();
  ard_block_if out_ch ();

  aligned_range_decomposer_core #(.ADDR_WIDTH(ADDR_WIDTH)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ard_checker #(.ADDR_WIDTH(ADDR_WIDTH)) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .blocks_owed    (blocks_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs; far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Receiver: rotate a ready pattern every falling edge, and swap in a new pattern
  // now and then. Patterns range from never stalling to stalling most cycles; bit 0
  // is forced high so no stall outlasts one rotation.
  always @(negedge clk) begin
    if (stall_age <= 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = '1;
        1:       stall_pattern = $urandom | 32'h1;
        2:       stall_pattern = $urandom | $urandom | 32'h1;
        default: stall_pattern = ($urandom & $urandom) | 32'h1;
      endcase
      stall_age = $urandom_range(16, 96);
    end
    out_ch.ready  = stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
    stall_age--;
  end

  // Offer one range item and hold it until the block takes it. Call at a falling
  // edge; return at the falling edge after the accept, with valid still high so a
  // back-to-back item needs no dip.
  task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    if (burst_left <= 0) begin
      // Close the burst: idle for a random gap (often none), then start a new one.
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid              = 1'b1;
    in_ch.payload.range_low  = lo;
    in_ch.payload.range_high = hi;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Write the numbering mode once the block has drained. Every item yields at least
  // one block, so an empty expectation store plus a short settle means idle.
  task automatic write_one_based(input logic mode);
    in_ch.valid = 1'b0;
    while (blocks_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mode;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Draw one random range. Most are well formed with random content; a few are
  // empty ranges or hug the ends of the space.
  task automatic draw_range(input logic mode, output logic [31:0] lo, output logic [31:0] hi);
    logic [32:0] wide_lo;
    logic [32:0] wide_hi;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned k;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    a    = $urandom;
    b    = $urandom;
    if (pick < 35) begin
      // Random start with a span of random magnitude; clamp at the top.
      wide_lo = {1'b0, a};
      wide_hi = wide_lo + {1'b0, b >> $urandom_range(0, 31)};
    end else if (pick < 55) begin
      // One exactly aligned block, shifted up by one in one-based numbering.
      k       = $urandom_range(0, 31);
      wide_lo = {1'b0, a} & ~((33'd1 << k) - 33'd1);
      wide_hi = wide_lo + (33'd1 << k) - 33'd1;
      if (mode) begin
        wide_lo = wide_lo + 33'd1;
        wide_hi = wide_hi + 33'd1;
      end
    end else if (pick < 80) begin
      // Two unrelated bounds in order.
      wide_lo = {1'b0, (a < b) ? a : b};
      wide_hi = {1'b0, (a < b) ? b : a};
    end else if (pick < 88) begin
      // Near zero: reaches the below-zero error in one-based numbering.
      wide_lo = 33'($urandom_range(0, 3));
      wide_hi = 33'($urandom_range(wide_lo[31:0], 40));
    end else if (pick < 94) begin
      // Near the top of the space.
      wide_hi = {1'b0, 32'hFFFF_FFFF} - 33'($urandom_range(0, 3));
      wide_lo = {1'b0, 32'hFFFF_FFFF} - 33'($urandom_range(0, 40));
    end else begin
      // Empty range: low above high.
      wide_lo = {1'b0, (a < b) ? b : a};
      wide_hi = {1'b0, (a < b) ? a : b};
      if (wide_lo == wide_hi) begin
        if (wide_hi != 33'd0) wide_hi = wide_hi - 33'd1;
        else wide_lo = 33'd1;
      end
    end
    if (wide_lo[32]) wide_lo = {1'b0, 32'hFFFF_FFFF};
    if (wide_hi[32]) wide_hi = {1'b0, 32'hFFFF_FFFF};
    lo = wide_lo[31:0];
    hi = wide_hi[31:0];
  endtask

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    logic        mode;
    int          waited;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    stall_pattern = '1;
    stall_age     = 0;
    burst_left    = 0;

    // Hold reset from time zero, release it on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed, zero-based numbering straight from reset.
    send_range(32'h0000_0000, 32'hFFFF_FFFF);  // whole space: one top-level block
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'h0000_0000);  // empty range
    send_range(32'hFFFF_FFFF, 32'h0000_0000);  // empty range, widest gap
    send_range(32'h0000_0001, 32'hFFFF_FFFE);  // most blocks any range can take
    send_range(32'h0000_0005, 32'h0000_0005);
    send_range(32'h0000_0000, 32'h0000_0007);
    send_range(32'h0000_0003, 32'h0000_000C);
    send_range(32'h8000_0000, 32'hFFFF_FFFF);
    send_range(32'h5555_5555, 32'hAAAA_AAAA);
    send_range(32'h0000_0000, 32'h7FFF_FFFF);

    // Directed, one-based numbering.
    write_one_based(1'b1);
    send_range(32'h0000_0000, 32'h0000_0005);  // lowered low bound goes below zero
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'h0000_0001, 32'h0000_0001);
    send_range(32'h0000_0001, 32'hFFFF_FFFF);  // widest one-based range
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_0002, 32'hFFFF_FFFF);
    send_range(32'h0000_0005, 32'h0000_0004);  // empty range
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'h0000_0001, 32'h0000_0008);
    send_range(32'h8000_0001, 32'hFFFF_FFFF);

    // Random phases, alternating the numbering mode between them.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = phase[0];
      write_one_based(mode);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        draw_range(mode, lo, hi);
        send_range(lo, hi);
      end
    end

    // Drop valid, drain what is owed, then let trailing output settle.
    in_ch.valid = 1'b0;
    waited      = 0;
    while (blocks_owed != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && blocks_owed == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
